[rtl/core/chunked_link_block_transfer_unit_macros.svh]
// Assertion macros used by the block-transfer port checker
`ifndef CHUNKED_LINK_BLOCK_TRANSFER_UNIT_MACROS_SVH
`define CHUNKED_LINK_BLOCK_TRANSFER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CLBT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clbt assertion failed");

// Next-cycle implication, disabled during reset
`define CLBT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clbt assertion failed");

`endif

[rtl/core/clbt_pkg.sv]
// Shared types and constants of the chunked link block transfer unit
package clbt_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_WORD  = 2'd2;

    localparam logic [1:0] KIND_WORD  = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_RETRY = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    localparam logic [15:0] CHECK_INIT = 16'hFFFF;
    localparam logic [15:0] TAG_RESET  = 16'h1101;
    localparam logic [4:0]  MAX_RESULTS = 5'd20;

    typedef struct packed {
        logic [1:0]  code;
        logic [31:0] data;
    } op_t;

    typedef struct packed {
        logic [5:0]  pad;
        logic        skip;
        logic        dir;
        logic [7:0]  len;
        logic [15:0] cmd;
    } start_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] word;
        logic [7:0]  data;
        logic        last;
    } res_t;

endpackage

[rtl/core/chunked_link_block_transfer_unit.sv]
// Top level of the chunked link block transfer unit
//
// Input side is a queue: present func and its fields with push; the
// transaction is taken when push is high and full is low. Start, send
// byte and link word transactions go into a two-entry operation queue.
// Result side is a queue: while empty is low the oldest result sits on
// kind/word_out/byte_out/last; pop takes it. Results wait in a four-entry
// output queue; a stalled receiver stops the sequencer rather than drop data.
// Config: one write channel (cfg_valid/cfg_ready, always ready) sets
// check_tag, reset 0x1101; write it only while the block is idle.
// Steps: a send data word takes four chunk-buffer reads, a wait for RAM
// read data and an emit; a released byte a buffer read and an emit; a
// link data word is unpacked into the buffer byte by byte; headers,
// retry and done marks are an emit each. Results past the twentieth of a
// transaction are dropped. The byte buffer holds CHUNK_BYTES entries.
// Reset clears the sequencer to idle and empties both queues; the chunk
// buffer needs no clearing.
module chunked_link_block_transfer_unit #(
    parameter int CHUNK_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  func,
    input  logic [15:0] command,
    input  logic [7:0]  total_length,
    input  logic        direction,
    input  logic        skip_check,
    input  logic [7:0]  data_byte,
    input  logic [31:0] link_word,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [31:0] word_out,
    output logic [7:0]  byte_out,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int AW = $clog2(CHUNK_BYTES);

    logic [15:0]    tag_reg;
    logic           op_valid, op_pop;
    clbt_pkg::op_t  op;
    logic           res_push, res_full;
    clbt_pkg::res_t res, res_head;
    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [7:0]     ram_wdata, ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= clbt_pkg::TAG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tag_reg <= cfg_data;
        end
    end

    clbt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .func         (func),
        .command      (command),
        .total_length (total_length),
        .direction    (direction),
        .skip_check   (skip_check),
        .data_byte    (data_byte),
        .link_word    (link_word),
        .op_pop       (op_pop),
        .op_valid     (op_valid),
        .op           (op)
    );

    clbt_back #(
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .check_tag (tag_reg),
        .op_valid  (op_valid),
        .op        (op),
        .op_pop    (op_pop),
        .res_push  (res_push),
        .res       (res),
        .res_full  (res_full),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    clbt_ram #(
        .WIDTH(8),
        .DEPTH(CHUNK_BYTES)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    clbt_fifo #(
        .WIDTH($bits(clbt_pkg::res_t)),
        .DEPTH(4)
    ) u_resq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_head),
        .empty (empty)
    );

    assign kind     = res_head.kind;
    assign word_out = res_head.word;
    assign byte_out = res_head.data;
    assign last     = res_head.last;

endmodule

[rtl/core/clbt_ram.sv]
// Generic single-write, single-read RAM with registered read data
module clbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/clbt_fifo.sv]
// Small register FIFO
module clbt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = count_reg == (AW+1)'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[rtl/core/clbt_front.sv]
// Front end: accepts input transactions, drops unknown codes, queues operations
module clbt_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         func,
    input  logic [15:0]        command,
    input  logic [7:0]         total_length,
    input  logic               direction,
    input  logic               skip_check,
    input  logic [7:0]         data_byte,
    input  logic [31:0]        link_word,
    input  logic               op_pop,
    output logic               op_valid,
    output clbt_pkg::op_t      op
);

    clbt_pkg::op_t    op_in;
    clbt_pkg::start_t st;
    logic             keep;
    logic             q_full, q_empty;

    always_comb
    begin
        st.pad  = '0;
        st.skip = skip_check;
        st.dir  = direction;
        st.len  = total_length;
        st.cmd  = command;
        op_in.code = func;
        op_in.data = '0;
        keep = 1'b1;
        case (func)
            clbt_pkg::OP_START: op_in.data = st;
            clbt_pkg::OP_BYTE:  op_in.data = {24'd0, data_byte};
            clbt_pkg::OP_WORD:  op_in.data = link_word;
            default:            keep = 1'b0;
        endcase
    end

    clbt_fifo #(
        .WIDTH($bits(clbt_pkg::op_t)),
        .DEPTH(2)
    ) u_opq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && keep),
        .wdata (op_in),
        .full  (q_full),
        .pop   (op_pop),
        .rdata (op),
        .empty (q_empty)
    );

    assign full     = q_full;
    assign op_valid = !q_empty;

endmodule

[rtl/core/clbt_back.sv]
// Back end: chunk sequencer that carries out queued operations and emits results
module clbt_back #(
    parameter int CHUNK_BYTES = 16,
    localparam int AW  = $clog2(CHUNK_BYTES),
    localparam int DW  = $clog2(CHUNK_BYTES + 1),
    localparam int BCW = $clog2(CHUNK_BYTES + 4)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [15:0]     check_tag,
    input  logic            op_valid,
    input  clbt_pkg::op_t   op,
    output logic            op_pop,
    output logic            res_push,
    output clbt_pkg::res_t  res,
    input  logic            res_full,
    output logic            ram_we,
    output logic [AW-1:0]   ram_waddr,
    output logic [7:0]      ram_wdata,
    output logic            ram_re,
    output logic [AW-1:0]   ram_raddr,
    input  logic [7:0]      ram_rdata
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BEGIN = 4'd1;
    localparam logic [3:0] S_SHDR  = 4'd2;
    localparam logic [3:0] S_SRD   = 4'd3;
    localparam logic [3:0] S_SWORD = 4'd4;
    localparam logic [3:0] S_RHDR  = 4'd5;
    localparam logic [3:0] S_RXW   = 4'd6;
    localparam logic [3:0] S_CHK   = 4'd7;
    localparam logic [3:0] S_RETRY = 4'd8;
    localparam logic [3:0] S_REL   = 4'd9;
    localparam logic [3:0] S_ADV   = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_COLLECT = 2'd1;
    localparam logic [1:0] PH_RECV    = 2'd2;
    localparam logic [1:0] PH_CHECK   = 2'd3;

    logic [3:0]     seq_reg, seq_next;
    logic [1:0]     phase_reg, phase_next;
    logic [BCW-1:0] bc_reg, bc_next;
    logic [7:0]     cidx_reg, cidx_next;
    logic [7:0]     rem_reg, rem_next;
    logic [15:0]    acc_reg, acc_next;
    logic [15:0]    base_reg, base_next;
    logic [1:0]     mode_reg, mode_next;
    logic [DW-1:0]  decl_reg, decl_next;
    logic [DW-1:0]  clen_reg, clen_next;
    logic [BCW-1:0] idx_reg, idx_next;
    logic [2:0]     k_reg, k_next;
    logic [31:0]    word_reg, word_next;
    logic [4:0]     rcnt_reg, rcnt_next;
    logic           vld_reg, vld_next;

    clbt_pkg::start_t st;
    logic [15:0]    cmd;
    logic [31:0]    hdr;
    logic           capped, emit_go;
    logic           em_req, em_last;
    logic [1:0]     em_kind;
    logic [31:0]    em_word;
    logic [7:0]     em_byte;
    logic [BCW:0]   pos;
    logic [DW-1:0]  cl;

    assign st      = clbt_pkg::start_t'(op.data);
    assign cmd     = base_reg + {8'd0, cidx_reg};
    assign hdr     = {16'(decl_reg), cmd};
    assign capped  = rcnt_reg == clbt_pkg::MAX_RESULTS;
    assign emit_go = capped || !res_full;

    always_comb
    begin
        seq_next   = seq_reg;
        phase_next = phase_reg;
        bc_next    = bc_reg;
        cidx_next  = cidx_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        mode_next  = mode_reg;
        decl_next  = decl_reg;
        clen_next  = clen_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        word_next  = word_reg;
        rcnt_next  = rcnt_reg;
        vld_next   = vld_reg;
        op_pop     = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        em_req     = 1'b0;
        em_last    = 1'b0;
        em_kind    = clbt_pkg::KIND_WORD;
        em_word    = '0;
        em_byte    = '0;
        pos        = '0;
        cl         = '0;

        case (seq_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    op_pop    = 1'b1;
                    rcnt_next = '0;
                    case (op.code)
                        clbt_pkg::OP_START:
                        begin
                            base_next = st.cmd;
                            rem_next  = st.len;
                            mode_next = {st.skip, st.dir};
                            cidx_next = '0;
                            seq_next  = S_BEGIN;
                        end
                        clbt_pkg::OP_BYTE:
                        begin
                            if (phase_reg == PH_COLLECT)
                            begin
                                if (bc_reg < BCW'(CHUNK_BYTES))
                                begin
                                    ram_we    = 1'b1;
                                    ram_waddr = bc_reg[AW-1:0];
                                    ram_wdata = op.data[7:0];
                                end
                                bc_next = bc_reg + 1'b1;
                                if (({1'b0, bc_reg} + 1'b1) >= (BCW+1)'(clen_reg))
                                begin
                                    seq_next = S_SHDR;
                                end
                            end
                        end
                        clbt_pkg::OP_WORD:
                        begin
                            word_next = op.data;
                            if (phase_reg == PH_RECV)
                            begin
                                acc_next = acc_reg ^ {op.data[23:16], op.data[31:24]}
                                                   ^ {op.data[7:0], op.data[15:8]};
                                k_next   = '0;
                                seq_next = S_RXW;
                            end
                            else if (phase_reg == PH_CHECK)
                            begin
                                seq_next = S_CHK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_BEGIN:
            begin
                cl = (rem_reg > 8'(CHUNK_BYTES)) ? DW'(CHUNK_BYTES) : DW'(rem_reg);
                clen_next = cl;
                decl_next = (cidx_reg == '0) ? cl : DW'(CHUNK_BYTES);
                bc_next   = '0;
                if (mode_reg[0])
                begin
                    seq_next = S_RHDR;
                end
                else if (cl == '0)
                begin
                    seq_next = S_SHDR;
                end
                else
                begin
                    phase_next = PH_COLLECT;
                    seq_next   = S_IDLE;
                end
            end
            S_RHDR:
            begin
                em_req  = 1'b1;
                em_word = hdr;
                em_last = 1'b1;
                if (emit_go)
                begin
                    acc_next   = clbt_pkg::CHECK_INIT;
                    bc_next    = '0;
                    phase_next = (decl_reg != '0) ? PH_RECV : PH_CHECK;
                    seq_next   = S_IDLE;
                end
            end
            S_SHDR:
            begin
                em_req  = 1'b1;
                em_word = hdr;
                em_last = decl_reg == '0;
                if (emit_go)
                begin
                    acc_next = clbt_pkg::CHECK_INIT ^ cmd ^ 16'(decl_reg);
                    idx_next = '0;
                    k_next   = '0;
                    if (decl_reg == '0)
                    begin
                        phase_next = PH_CHECK;
                        seq_next   = S_IDLE;
                    end
                    else
                    begin
                        seq_next = S_SRD;
                    end
                end
            end
            S_SRD:
            begin
                // read four bytes, zero past the real chunk length
                pos = {1'b0, idx_reg} + (BCW+1)'(k_reg);
                if (k_reg < 3'd4)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = pos[AW-1:0];
                    vld_next  = pos < (BCW+1)'(clen_reg);
                end
                if (k_reg != 3'd0)
                begin
                    word_next = {(vld_reg ? ram_rdata : 8'd0), word_reg[31:8]};
                end
                if (k_reg == 3'd4)
                begin
                    k_next   = '0;
                    seq_next = S_SWORD;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_SWORD:
            begin
                em_req  = 1'b1;
                em_word = word_reg;
                em_last = ({1'b0, idx_reg} + (BCW+1)'(4)) >= (BCW+1)'(decl_reg);
                if (emit_go)
                begin
                    acc_next = acc_reg ^ word_reg[15:0] ^ word_reg[31:16];
                    idx_next = idx_reg + BCW'(4);
                    if (em_last)
                    begin
                        phase_next = PH_CHECK;
                        seq_next   = S_IDLE;
                    end
                    else
                    begin
                        seq_next = S_SRD;
                    end
                end
            end
            S_RXW:
            begin
                // big-endian unpack, one byte per cycle
                pos = {1'b0, bc_reg} + (BCW+1)'(k_reg);
                if (pos < (BCW+1)'(CHUNK_BYTES))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pos[AW-1:0];
                    ram_wdata = word_reg[31:24];
                end
                word_next = {word_reg[23:0], 8'd0};
                k_next    = k_reg + 1'b1;
                if (k_reg == 3'd3)
                begin
                    bc_next = bc_reg + BCW'(4);
                    if (({1'b0, bc_reg} + (BCW+1)'(4)) >= (BCW+1)'(decl_reg))
                    begin
                        phase_next = PH_CHECK;
                    end
                    seq_next = S_IDLE;
                end
            end
            S_CHK:
            begin
                idx_next = '0;
                k_next   = '0;
                if (mode_reg[1] || word_reg == {check_tag, acc_reg})
                begin
                    seq_next = (mode_reg[0] && clen_reg != '0) ? S_REL : S_ADV;
                end
                else
                begin
                    seq_next = S_RETRY;
                end
            end
            S_RETRY:
            begin
                em_req  = 1'b1;
                em_kind = clbt_pkg::KIND_RETRY;
                if (emit_go)
                begin
                    seq_next = mode_reg[0] ? S_RHDR : S_SHDR;
                end
            end
            S_REL:
            begin
                if (k_reg == 3'd0)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg[AW-1:0];
                    k_next    = 3'd1;
                end
                else
                begin
                    em_req  = 1'b1;
                    em_kind = clbt_pkg::KIND_BYTE;
                    em_byte = ram_rdata;
                    if (emit_go)
                    begin
                        k_next   = '0;
                        idx_next = idx_reg + 1'b1;
                        if (({1'b0, idx_reg} + 1'b1) == (BCW+1)'(clen_reg))
                        begin
                            seq_next = S_ADV;
                        end
                    end
                end
            end
            S_ADV:
            begin
                rem_next  = rem_reg - 8'(clen_reg);
                cidx_next = cidx_reg + 1'b1;
                seq_next  = (rem_reg == 8'(clen_reg)) ? S_DONE : S_BEGIN;
            end
            S_DONE:
            begin
                em_req  = 1'b1;
                em_kind = clbt_pkg::KIND_DONE;
                em_last = 1'b1;
                if (emit_go)
                begin
                    phase_next = PH_IDLE;
                    seq_next   = S_IDLE;
                end
            end
            default:
            begin
                seq_next = S_IDLE;
            end
        endcase

        res_push = em_req && !capped && !res_full;
        res.kind = em_kind;
        res.word = em_word;
        res.data = em_byte;
        res.last = em_last || (rcnt_reg == clbt_pkg::MAX_RESULTS - 5'd1);
        if (res_push)
        begin
            rcnt_next = rcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= S_IDLE;
            phase_reg <= PH_IDLE;
            bc_reg    <= '0;
            cidx_reg  <= '0;
            rem_reg   <= '0;
            acc_reg   <= clbt_pkg::CHECK_INIT;
            base_reg  <= '0;
            mode_reg  <= '0;
            decl_reg  <= '0;
            clen_reg  <= '0;
            idx_reg   <= '0;
            k_reg     <= '0;
            rcnt_reg  <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            seq_reg   <= seq_next;
            phase_reg <= phase_next;
            bc_reg    <= bc_next;
            cidx_reg  <= cidx_next;
            rem_reg   <= rem_next;
            acc_reg   <= acc_next;
            base_reg  <= base_next;
            mode_reg  <= mode_next;
            decl_reg  <= decl_next;
            clen_reg  <= clen_next;
            idx_reg   <= idx_next;
            k_reg     <= k_next;
            rcnt_reg  <= rcnt_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

[rtl/core/clbt_checker.sv]
// Port-level checker for the block transfer unit, bound to the top level
`include "chunked_link_block_transfer_unit_macros.svh"

module clbt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  kind,
    input logic [31:0] word_out,
    input logic        last
);

    `CLBT_ASSERT_NOW(a_done_is_last, !empty && kind == clbt_pkg::KIND_DONE, last)
    `CLBT_ASSERT_NOW(a_retry_not_last, !empty && kind == clbt_pkg::KIND_RETRY, !last)
    `CLBT_ASSERT_NOW(a_word_only_for_link, !empty && kind != clbt_pkg::KIND_WORD, word_out == 32'd0)
    `CLBT_ASSERT_NEXT(a_result_held, !empty && !pop, !empty)

endmodule

bind chunked_link_block_transfer_unit clbt_checker u_clbt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .kind     (kind),
    .word_out (word_out),
    .last     (last)
);

[tb/clbt_result_checker.sv]
// Result checker for the chunked link block transfer unit: predicts and compares results
module clbt_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [1:0]  func,
    input  logic [15:0] command,
    input  logic [7:0]  total_length,
    input  logic        direction,
    input  logic        skip_check,
    input  logic [7:0]  data_byte,
    input  logic [31:0] link_word,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  kind,
    input  logic [31:0] word_out,
    input  logic [7:0]  byte_out,
    input  logic        last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output logic [31:0] good_check
);

    localparam int CHUNK = 16;
    localparam int MEM_SIZE = CHUNK + 4;

    typedef enum logic [1:0] {ST_IDLE, ST_COLLECT, ST_RECV, ST_CHECK} stage_e;

    logic [15:0] tag;
    stage_e      stage;
    logic [7:0]  chunk_mem [MEM_SIZE];
    int          byte_cnt;
    int          chunk_idx;
    int          remaining;
    logic [15:0] acc;
    logic [15:0] base_cmd;
    logic        recv_mode;
    logic        skip_mode;
    int          decl_len;
    int          chunk_len;

    clbt_pkg::res_t step_results[$];
    clbt_pkg::res_t expected_results[$];

    assign good_check = {tag, acc};

    function automatic void emit_result(logic [1:0] k, logic [31:0] w, logic [7:0] b);
        clbt_pkg::res_t r;
        if (step_results.size() < int'(clbt_pkg::MAX_RESULTS))
        begin
            r.kind = k;
            r.word = w;
            r.data = b;
            r.last = 1'b0;
            step_results.push_back(r);
        end
    endfunction

    function automatic logic [15:0] chunk_command();
        return base_cmd + 16'(chunk_idx);
    endfunction

    function automatic void send_block();
        logic [7:0] b [4];
        emit_result(clbt_pkg::KIND_WORD, {16'(decl_len), chunk_command()}, 8'd0);
        acc = clbt_pkg::CHECK_INIT ^ chunk_command() ^ 16'(decl_len);
        for (int i = 0; i < decl_len; i += 4)
        begin
            for (int k = 0; k < 4; k++)
                b[k] = (i + k < chunk_len) ? chunk_mem[i + k] : 8'd0;
            emit_result(clbt_pkg::KIND_WORD, {b[3], b[2], b[1], b[0]}, 8'd0);
            acc ^= {b[1], b[0]};
            acc ^= {b[3], b[2]};
        end
        stage = ST_CHECK;
    endfunction

    function automatic void recv_block();
        emit_result(clbt_pkg::KIND_WORD, {16'(decl_len), chunk_command()}, 8'd0);
        acc = clbt_pkg::CHECK_INIT;
        byte_cnt = 0;
        stage = (decl_len > 0) ? ST_RECV : ST_CHECK;
    endfunction

    function automatic void open_block();
        chunk_len = (remaining > CHUNK) ? CHUNK : remaining;
        decl_len = (chunk_idx == 0) ? chunk_len : CHUNK;
        byte_cnt = 0;
        if (recv_mode)
            recv_block();
        else if (chunk_len == 0)
            send_block();
        else
            stage = ST_COLLECT;
    endfunction

    function automatic void take_check(logic [31:0] w);
        if (!(skip_mode || w == {tag, acc}))
        begin
            emit_result(clbt_pkg::KIND_RETRY, 32'd0, 8'd0);
            if (recv_mode)
                recv_block();
            else
                send_block();
            return;
        end
        if (recv_mode)
            for (int i = 0; i < chunk_len; i++)
                emit_result(clbt_pkg::KIND_BYTE, 32'd0, chunk_mem[i]);
        remaining -= chunk_len;
        chunk_idx++;
        if (remaining == 0)
        begin
            emit_result(clbt_pkg::KIND_DONE, 32'd0, 8'd0);
            stage = ST_IDLE;
        end
        else
            open_block();
    endfunction

    function automatic void take_link_word(logic [31:0] w);
        logic [7:0] b [4];
        b[0] = w[31:24];
        b[1] = w[23:16];
        b[2] = w[15:8];
        b[3] = w[7:0];
        for (int k = 0; k < 4; k++)
            if (byte_cnt + k < MEM_SIZE)
                chunk_mem[byte_cnt + k] = b[k];
        acc ^= {b[1], b[0]};
        acc ^= {b[3], b[2]};
        byte_cnt += 4;
        if (byte_cnt >= decl_len)
            stage = ST_CHECK;
    endfunction

    function automatic void predict_transaction();
        step_results.delete();
        if (func == clbt_pkg::OP_START)
        begin
            base_cmd = command;
            remaining = total_length;
            recv_mode = direction;
            skip_mode = skip_check;
            chunk_idx = 0;
            open_block();
        end
        else if (func == clbt_pkg::OP_BYTE)
        begin
            if (stage == ST_COLLECT)
            begin
                if (byte_cnt < MEM_SIZE)
                    chunk_mem[byte_cnt] = data_byte;
                byte_cnt++;
                if (byte_cnt >= chunk_len)
                    send_block();
            end
        end
        else if (func == clbt_pkg::OP_WORD)
        begin
            if (stage == ST_RECV)
                take_link_word(link_word);
            else if (stage == ST_CHECK)
                take_check(link_word);
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i])
            expected_results.push_back(step_results[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        clbt_pkg::res_t want;
        if (!rst_n)
        begin
            tag = clbt_pkg::TAG_RESET;
            stage = ST_IDLE;
            byte_cnt = 0;
            chunk_idx = 0;
            remaining = 0;
            acc = clbt_pkg::CHECK_INIT;
            base_cmd = '0;
            recv_mode = 1'b0;
            skip_mode = 1'b0;
            decl_len = 0;
            chunk_len = 0;
            expected_results.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transaction kind=%0d", kind);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, kind);
                        fail_count++;
                    end
                    if (word_out !== want.word)
                    begin
                        $error("word_out: expected %h, got %h", want.word, word_out);
                        fail_count++;
                    end
                    if (byte_out !== want.data)
                    begin
                        $error("byte_out: expected %h, got %h", want.data, byte_out);
                        fail_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                tag = cfg_data;
            if (push && !full)
                predict_transaction();
            pending = expected_results.size();
        end
    end

endmodule

[tb/testbench.sv]
// Testbench top for the chunked link block transfer unit: stimulus and verdict
module testbench;

    localparam logic [1:0] OP_BAD = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  func;
    logic [15:0] command;
    logic [7:0]  total_length;
    logic        direction;
    logic        skip_check;
    logic [7:0]  data_byte;
    logic [31:0] link_word;
    logic        empty;
    logic        pop;
    logic [1:0]  kind;
    logic [31:0] word_out;
    logic [7:0]  byte_out;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    int          fail_count;
    int          pending;
    logic [31:0] good_check;
    int          item_count;
    int          burst_left;
    int          quiet_cycles;
    int          stall_mode;
    int          cycle_count;

    chunked_link_block_transfer_unit uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .func(func),
        .command(command), .total_length(total_length), .direction(direction),
        .skip_check(skip_check), .data_byte(data_byte), .link_word(link_word),
        .empty(empty), .pop(pop), .kind(kind), .word_out(word_out),
        .byte_out(byte_out), .last(last), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    clbt_result_checker result_check (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .func(func),
        .command(command), .total_length(total_length), .direction(direction),
        .skip_check(skip_check), .data_byte(data_byte), .link_word(link_word),
        .empty(empty), .pop(pop), .kind(kind), .word_out(word_out),
        .byte_out(byte_out), .last(last), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_data(cfg_data), .fail_count(fail_count),
        .pending(pending), .good_check(good_check)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver stall pattern, switched at random among four pop modes
    always @(negedge clk)
    begin
        cycle_count++;
        if (cycle_count % 64 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 1) == 0);
            2: pop <= ($urandom_range(0, 3) == 0);
            default: pop <= (cycle_count % 8 < 5);
        endcase
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= 20000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_item(logic [1:0] f, logic [15:0] cmd, logic [7:0] len,
                             logic dir, logic skp, logic [7:0] db, logic [31:0] lw);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        func = f;
        command = cmd;
        total_length = len;
        direction = dir;
        skip_check = skp;
        data_byte = db;
        link_word = lw;
        push = 1'b1;
        do @(posedge clk); while (full);
        @(negedge clk);
        push = 1'b0;
        burst_left--;
        item_count++;
    endtask

    task automatic start_xfer(logic [15:0] cmd, logic [7:0] len, logic dir, logic skp);
        push_item(clbt_pkg::OP_START, cmd, len, dir, skp, 8'($urandom), $urandom);
    endtask

    task automatic send_byte(logic [7:0] b);
        push_item(clbt_pkg::OP_BYTE, 16'($urandom), 8'($urandom), 1'($urandom),
                  1'($urandom), b, $urandom);
    endtask

    task automatic send_word(logic [31:0] w);
        push_item(clbt_pkg::OP_WORD, 16'($urandom), 8'($urandom), 1'($urandom),
                  1'($urandom), 8'($urandom), w);
    endtask

    // one transfer, aborted at random per abort_pct; bad_pct sets how often a wrong check word is sent
    task automatic run_transfer(logic [15:0] cmd, int len, logic dir, logic skp,
                                int bad_pct, int abort_pct);
        int  rem;
        int  idx;
        int  clen;
        int  decl;
        bit  passed;
        bit  bad;
        rem = len;
        idx = 0;
        start_xfer(cmd, 8'(len), dir, skp);
        do
        begin
            clen = (rem > 16) ? 16 : rem;
            decl = (idx == 0) ? clen : 16;
            if (!dir)
                for (int i = 0; i < clen; i++)
                begin
                    if ($urandom_range(0, 99) < abort_pct)
                        return;
                    send_byte(8'($urandom));
                end
            do
            begin
                if (dir)
                    for (int i = 0; i < decl; i += 4)
                        send_word($urandom);
                bad = ($urandom_range(0, 99) < bad_pct);
                if (bad)
                    send_word(good_check ^ (32'd1 << $urandom_range(0, 31)));
                else
                    send_word(good_check);
                passed = skp || !bad;
                if ($urandom_range(0, 99) < abort_pct)
                    return;
            end
            while (!passed);
            rem -= clen;
            idx++;
        end
        while (rem > 0);
    endtask

    task automatic write_tag(logic [15:0] v);
        while (pending != 0) @(negedge clk);
        repeat (150) @(negedge clk);
        cfg_data = v;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_phase(int items_end);
        int len;
        while (item_count < items_end)
        begin
            case ($urandom_range(0, 19))
                0: push_item(OP_BAD, 16'($urandom), 8'($urandom), 1'($urandom),
                             1'($urandom), 8'($urandom), $urandom);
                1: send_byte(8'($urandom));
                2: send_word($urandom);
                3: run_transfer(16'($urandom), $urandom_range(128, 255), 1'b1, 1'b1, 0, 0);
                default:
                begin
                    len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3)
                                                      : $urandom_range(1, 40);
                    run_transfer(16'($urandom), len, 1'($urandom),
                                 ($urandom_range(0, 3) == 0), 25, 2);
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        func = clbt_pkg::OP_START;
        command = '0;
        total_length = '0;
        direction = 1'b0;
        skip_check = 1'b0;
        data_byte = '0;
        link_word = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        item_count = 0;
        burst_left = 0;
        quiet_cycles = 0;
        stall_mode = 0;
        cycle_count = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed
        run_transfer(16'h0000, 0, 1'b0, 1'b0, 0, 0);
        run_transfer(16'hFFFF, 0, 1'b1, 1'b1, 100, 0);
        send_word(32'hFFFF_FFFF);
        run_transfer(16'hFFFF, 5, 1'b0, 1'b0, 0, 0);
        run_transfer(16'h1234, 3, 1'b1, 1'b0, 0, 0);
        push_item(OP_BAD, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 8'hFF, 32'hFFFF_FFFF);
        send_byte(8'hFF);
        start_xfer(16'hABCD, 8'd4, 1'b0, 1'b0);
        send_byte(8'h00);
        run_transfer(16'hFFF0, 20, 1'b0, 1'b1, 50, 0);
        write_tag(16'hFFFF);
        run_transfer(16'h8000, 17, 1'b1, 1'b0, 30, 0);

        random_phase(110);
        write_tag(16'h0000);
        random_phase(210);
        write_tag(16'($urandom));
        random_phase(310);

        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/clbt_pkg.sv
rtl/core/clbt_ram.sv
rtl/core/clbt_fifo.sv
rtl/core/clbt_front.sv
rtl/core/clbt_back.sv
rtl/core/chunked_link_block_transfer_unit.sv
rtl/core/clbt_checker.sv
tb/clbt_result_checker.sv
tb/testbench.sv
